### hdl/dcpec_pkg.sv
// Shared types, constants and the CRC-15 byte step for the daisy-chain write framer.
package dcpec_pkg;

    localparam int DEF_MAX_DEVICES = 16;
    localparam int DEF_GROUP_BYTES = 6;

    localparam logic [14:0] PEC_SEED  = 15'd16;
    localparam logic [14:0] PEC_POLY  = 15'h4599;
    localparam logic [2:0]  CMD_BYTES = 3'd2;

    // One result waiting in the output queue.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_pec;
        logic       frame_end;
        logic       last;
    } out_item_t;

    // Advances the 15-bit remainder by one byte, most significant bit first.
    function automatic logic [14:0] crc15_byte(input logic [14:0] rem, input logic [7:0] din);
        logic [14:0] r;
        r = rem ^ {din, 7'd0};
        for (int b = 0; b < 8; b++) begin
            if (r[14]) begin
                r = {r[13:0], 1'b0} ^ PEC_POLY;
            end else begin
                r = {r[13:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

### hdl/daisy_chain_pec15_write_framer_core.sv
// Top level of the daisy-chain write framer: frame sequencing, PEC and output queue.
//
// Usage. Command and payload bytes enter one per transfer on the s_ channel
// (s_tdata = data byte, s_tuser = frame start). Each byte is echoed on the
// m_ channel. When the byte closes a group (two command bytes, then
// GROUP_BYTES bytes for each of ic_count devices) the echo is followed by
// the group's two PEC bytes, high byte first; m_tuser[0] marks PEC bytes,
// m_tuser[1] marks the final PEC byte of the frame and m_tlast marks the
// last result belonging to one input byte.
// Each echo is on m_ in the cycle after its input transfer. One byte per
// cycle is taken while no group closes and the receiver does not stall; a
// closing byte fills the three-entry output queue, and the next byte is
// taken as its final PEC byte leaves. The CRC step is combinational. The
// ic_count register is written through cfg_wr_en / cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce;
// values above MAX_DEVICES act as MAX_DEVICES. Reset clears the queue,
// returns the sequencer to the command group with the PEC seed loaded and sets
// ic_count to one. When the receiver stalls, the current result holds on m_
// and s_tready drops as soon as the queue cannot take another item's results.
module daisy_chain_pec15_write_framer_core #(
    parameter int MAX_DEVICES = dcpec_pkg::DEF_MAX_DEVICES,
    parameter int GROUP_BYTES = dcpec_pkg::DEF_GROUP_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] frame_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] is_pec, [1] frame_end
    output logic       m_tlast    // last result of one input byte
);
    import dcpec_pkg::*;

    localparam logic [2:0] GROUP_LEN = 3'(GROUP_BYTES);
    localparam logic [4:0] MAX_DEV   = 5'(MAX_DEVICES);

    // Configuration and sequencer state.
    logic [4:0]  ic_count_reg;
    logic [14:0] crc_reg, crc_next;
    logic [2:0]  pos_reg, pos_next;
    logic [4:0]  group_reg, group_next;

    // Output queue: entry 0 is the one presented on m_.
    out_item_t   slot_reg [3];
    logic [1:0]  cnt_reg;

    logic        s_fire, m_fire;
    logic        start;
    logic [4:0]  grp_cur;
    logic [14:0] crc_cur, crc_step;
    logic [2:0]  pos_step, glen;
    logic [4:0]  count_eff;
    logic        complete, final_grp;
    logic [15:0] pec;

    // The queue takes a new item when empty, or when its only entry leaves now.
    assign m_tvalid = (cnt_reg != 2'd0);
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign m_tdata  = slot_reg[0].out_byte;
    assign m_tuser  = {slot_reg[0].frame_end, slot_reg[0].is_pec};
    assign m_tlast  = slot_reg[0].last;

    // A frame start forces the command group with a fresh remainder.
    always_comb begin
        start     = s_tuser[0];
        grp_cur   = start ? 5'd0 : group_reg;
        crc_cur   = start ? PEC_SEED : crc_reg;
        crc_step  = crc15_byte(crc_cur, s_tdata);
        pos_step  = (start ? 3'd0 : pos_reg) + 3'd1;
        glen      = (grp_cur == 5'd0) ? CMD_BYTES : GROUP_LEN;
        complete  = (pos_step >= glen);
        count_eff = (ic_count_reg > MAX_DEV) ? MAX_DEV : ic_count_reg;
        final_grp = (grp_cur >= count_eff);
        pec       = {crc_step, 1'b0};

        if (complete) begin
            // The group closes: reload the seed and step to the next group,
            // or back to the command group when the frame is done.
            crc_next   = PEC_SEED;
            pos_next   = 3'd0;
            group_next = final_grp ? 5'd0 : grp_cur + 5'd1;
        end else begin
            crc_next   = crc_step;
            pos_next   = pos_step;
            group_next = grp_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ic_count_reg <= 5'd1;
            crc_reg      <= PEC_SEED;
            pos_reg      <= 3'd0;
            group_reg    <= 5'd0;
            cnt_reg      <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                ic_count_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                crc_reg   <= crc_next;
                pos_reg   <= pos_next;
                group_reg <= group_next;
                cnt_reg   <= complete ? 2'd3 : 2'd1;
            end else if (m_fire) begin
                cnt_reg   <= cnt_reg - 2'd1;
            end
        end
    end

    // Queue payload needs no reset; the count qualifies it.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            slot_reg[0] <= '{out_byte: s_tdata, is_pec: 1'b0, frame_end: 1'b0,
                             last: !complete};
            slot_reg[1] <= '{out_byte: pec[15:8], is_pec: 1'b1, frame_end: 1'b0,
                             last: 1'b0};
            slot_reg[2] <= '{out_byte: pec[7:0], is_pec: 1'b1, frame_end: final_grp,
                             last: 1'b1};
        end else if (m_fire) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

### hdl/dcpec_checker.sv
// Port-level checker for the daisy-chain write framer, bound to the top level.
module dcpec_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // The frame end is always the closing PEC byte of an item.
    a_frame_end_pec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
        else $error("frame end on a byte that is not the closing PEC");

    // Input is taken beside a pending result only when that result closes its item.
    a_ready_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast && m_tready)
        else $error("input taken while an item's results are still queued");

    // A PEC high byte is followed by the PEC low byte.
    a_pec_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] && !m_tlast |=> m_tvalid && m_tuser[0] && m_tlast)
        else $error("PEC high byte not followed by PEC low byte");

endmodule

bind daisy_chain_pec15_write_framer_core dcpec_checker u_dcpec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### dv/testbench.sv
// Self-checking testbench for the daisy-chain PEC-15 write framer core.
`timescale 1ns / 1ps

module testbench;

    // Sizes and PEC constants are taken from the package, so the checker
    // follows the same configuration as the block under test.
    localparam int          DEVICE_CAP = dcpec_pkg::DEF_MAX_DEVICES;
    localparam int          PAYLOAD_LEN = dcpec_pkg::DEF_GROUP_BYTES;
    localparam int          COMMAND_LEN = int'(dcpec_pkg::CMD_BYTES);
    localparam logic [14:0] CRC_SEED = dcpec_pkg::PEC_SEED;
    localparam logic [14:0] CRC_POLY = dcpec_pkg::PEC_POLY;

    // A cycle without any transfer on either channel counts towards this limit.
    // The longest legitimate quiet stretch is the deliberate receiver hold-off.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef dcpec_pkg::out_item_t tx_byte_t;

    // Receiver behaviour, picked afresh at random for each spell of cycles.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_MOSTLY
    } rx_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [4:0] cfg_wr_data = 5'd0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic [0:0] s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    daisy_chain_pec15_write_framer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 8 ns period: high for half, low for half.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor: its own copy of the register and sequencer state.
    // ------------------------------------------------------------------
    logic [4:0]  dev_count = 5'd1;
    logic [14:0] group_crc = CRC_SEED;
    logic [2:0]  group_fill = 3'd0;
    logic [4:0]  group_num = 5'd0;

    // Bytes the framer is due to transmit, oldest first.
    tx_byte_t tx_due_q[$];

    int mismatches = 0;

    // The CRC written as a serial shift register: each data bit, most
    // significant first, is folded into the feedback term.
    function automatic logic [14:0] crc15_step(input logic [14:0] rem, input logic [7:0] din);
        logic [14:0] r;
        logic        fb;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            fb = r[14] ^ din[i];
            r = {r[13:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic int frame_length(input logic [4:0] count);
        int eff;
        eff = (count > DEVICE_CAP) ? DEVICE_CAP : count;
        return COMMAND_LEN + PAYLOAD_LEN * eff;
    endfunction

    // Works out what one accepted byte makes the framer send, and queues it.
    task automatic predict_frame_bytes(input logic [7:0] din, input logic start);
        tx_byte_t    item;
        logic [4:0]  eff;
        logic [2:0]  glen;
        logic [15:0] pec;
        logic        closes_frame;
        eff = (dev_count > DEVICE_CAP) ? 5'(DEVICE_CAP) : dev_count;
        if (start) begin
            group_num = 5'd0;
            group_crc = CRC_SEED;
            group_fill = 3'd0;
        end
        group_crc = crc15_step(group_crc, din);
        group_fill = group_fill + 3'd1;
        glen = (group_num == 5'd0) ? 3'(COMMAND_LEN) : 3'(PAYLOAD_LEN);
        if (group_fill < glen) begin
            item = '{out_byte: din, is_pec: 1'b0, frame_end: 1'b0, last: 1'b1};
            tx_due_q.push_back(item);
        end else begin
            // The group closes: echo, then the doubled remainder, high byte first.
            pec = {group_crc, 1'b0};
            closes_frame = (group_num >= eff);
            item = '{out_byte: din, is_pec: 1'b0, frame_end: 1'b0, last: 1'b0};
            tx_due_q.push_back(item);
            item = '{out_byte: pec[15:8], is_pec: 1'b1, frame_end: 1'b0, last: 1'b0};
            tx_due_q.push_back(item);
            item = '{out_byte: pec[7:0], is_pec: 1'b1, frame_end: closes_frame, last: 1'b1};
            tx_due_q.push_back(item);
            group_num = closes_frame ? 5'd0 : group_num + 5'd1;
            group_crc = CRC_SEED;
            group_fill = 3'd0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Offers one byte and returns at the falling edge after its transfer,
    // with s_tvalid still high so that the next byte can follow at once.
    task automatic push_byte(input logic [7:0] din, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata <= din;
        s_tuser <= start;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predict_frame_bytes(din, start);
        @(negedge aclk);
    endtask

    // Lowers s_tvalid and forces a fresh gap decision for the next byte.
    task automatic quiesce_sender();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // The register is only written once everything due has come out.
    task automatic set_ic_count(input logic [4:0] value);
        quiesce_sender();
        while (tx_due_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        dev_count = value;
    endtask

    // ------------------------------------------------------------------
    // Receiver: a stall pattern of its own, plus an occasional long hold-off
    // requested by a test and counted here.
    // ------------------------------------------------------------------
    int       hold_requests = 0;
    int       holds_served = 0;
    int       hold_left = 0;
    int       rx_mode_left = 0;
    int       rx_tick = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    always @(negedge aclk) begin
        rx_tick++;
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 80);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                RX_PATTERN: begin
                    m_tready <= ((rx_tick % 5) < 3);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 6) != 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every m_ transfer is matched against the oldest byte due.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tx_byte_t got;
        tx_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{out_byte: m_tdata, is_pec: m_tuser[0], frame_end: m_tuser[1],
                    last: m_tlast};
            if (tx_due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected transfer byte=%02h pec=%b end=%b last=%b",
                             $realtime, got.out_byte, got.is_pec, got.frame_end, got.last);
                end
            end else begin
                want = tx_due_q.pop_front();
                if (got.out_byte !== want.out_byte || got.is_pec !== want.is_pec ||
                    got.frame_end !== want.frame_end || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: mismatch expected byte=%02h pec=%b end=%b last=%b, %s",
                                 $realtime, want.out_byte, want.is_pec, want.frame_end,
                                 want.last, "see actual below");
                        $display("%0t:          actual   byte=%02h pec=%b end=%b last=%b",
                                 $realtime, got.out_byte, got.is_pec, got.frame_end,
                                 got.last);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The reset count of one device: command, one payload group, frame end.
    // The data extremes travel through the CRC here.
    task automatic test_default_count_frame();
        logic [7:0] bytes [8];
        bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hFF, 8'h00, 8'h7F, 8'hA5};
        for (int i = 0; i < 8; i++) begin
            push_byte(bytes[i], i == 0);
        end
    endtask

    // Count zero gives command-only frames; the second frame follows the
    // frame end without a frame start, since the sequencer is back at the
    // command group.
    task automatic test_command_only_frames();
        set_ic_count(5'd0);
        push_byte(8'h11, 1'b1);
        push_byte(8'hEE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
    endtask

    // A frame start in the middle of a payload group throws the group away.
    task automatic test_restart_mid_group();
        set_ic_count(5'd1);
        push_byte(8'h3C, 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h5A, 1'b1);
    endtask

    // The count is lowered after the command group has gone out, so the
    // next group to complete closes the frame on its own.
    task automatic test_count_lowered_mid_frame();
        set_ic_count(5'd1);
        push_byte(8'h01, 1'b1);
        push_byte(8'h02, 1'b0);
        set_ic_count(5'd0);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // An oversized count acts as the device cap. The receiver holds off for
    // a long stretch at the start, so the output queue fills and s_tready
    // drops while the sender keeps offering bytes.
    task automatic test_oversized_count_with_backpressure();
        int len;
        set_ic_count(5'd31);
        len = frame_length(5'd31);
        hold_requests++;
        for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)), i == 0);
        end
    endtask

    // Mostly well-formed frames with random content; the rest are truncated
    // frames, frames without a start marker and loose noise bytes.
    task automatic test_random_frames(input logic [4:0] count, input int budget);
        int sent;
        int len;
        int n;
        int kind;
        set_ic_count(count);
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(0, 9);
            len = frame_length(count);
            if (kind <= 6) begin
                n = len;
                for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == 0);
            end else if (kind == 7) begin
                n = $urandom_range(1, len - 1);
                for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == 0);
            end else if (kind == 8) begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) begin
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end else begin
                n = len;
                for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            sent += n;
        end
    endtask

    initial begin
        // Reset is applied once, at the start of the run.
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_count_frame();
        test_command_only_frames();
        test_restart_mid_group();
        test_count_lowered_mid_frame();
        test_oversized_count_with_backpressure();

        // Small counts carry the random traffic; the device cap is already
        // covered by the oversized count above.
        test_random_frames(5'd0, 10);
        test_random_frames(5'd1, 25);
        test_random_frames(5'd2, 25);
        test_random_frames(5'd3, 20);
        test_random_frames(5'd1, 10);

        // Drain: everything due must arrive, then nothing more may follow.
        quiesce_sender();
        while (tx_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && tx_due_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/dcpec_pkg.sv
hdl/daisy_chain_pec15_write_framer_core.sv
hdl/dcpec_checker.sv
dv/testbench.sv
